[rtl/core/v3fx_pkg.sv]
// Shared types and constants for the fixed-point 3D vector unit.
package v3fx_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FUNC_W         = 3;

  // operation codes; the remaining code returns all zeros
  typedef enum logic [FUNC_W-1:0] {
    FN_DOT   = 3'd0,
    FN_CROSS = 3'd1,
    FN_SCALE = 3'd2,
    FN_LERP  = 3'd3,
    FN_NORM  = 3'd4,
    FN_LEN   = 3'd5,
    FN_LENSQ = 3'd6
  } func_t;

  typedef struct packed {
    func_t func;
    logic  zl;
    logic  ovf;
  } ctl_t;

endpackage

[rtl/core/vector3_fixed_point_alu_top.sv]
// Top level of the fixed-point 3D vector unit: front end, root and divide chains, output register.
// Path from input transfer to result, for operands in Q16.16 by default: three front-end stages,
// one root cell per root bit, one divide cell per quotient bit, then the output register.
// Throughput: one item per cycle while m_tready is high; every stage holds its own valid bit
// and stalls only when full. Every operation takes the same path, so results leave in input order.
// Reset: rst (synchronous) clears all valid bits; data registers are not reset.
module vector3_fixed_point_alu_top #(
  parameter int DATA_WIDTH = v3fx_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = v3fx_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // ax, ay, az, bx, by, bz, scalar_t
  input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]     s_tdata,
  // func
  input  logic [v3fx_pkg::FUNC_W-1:0]           s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // rx, ry, rz, rscalar
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
  // zero_length, overflow
  output logic [1:0]                            m_tuser
);
  import v3fx_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int QW     = FRAC_BITS + 2;
  localparam int LW     = W + FRAC_BITS + 2;
  localparam int OUT_TW = ((4*W+7)/8)*8;
  localparam int RS_W   = 7 * W + 3;
  localparam int DS_W   = 4 * W + 3;
  localparam int XW     = QW + W + 1;
  localparam logic signed [XW-1:0] MAXX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] MINX = ~MAXX;

  function automatic logic [W-1:0] sat_x(input logic signed [XW-1:0] v);
    if (v > MAXX) begin
      return MAXX[W-1:0];
    end else if (v < MINX) begin
      return MINX[W-1:0];
    end
    return v[W-1:0];
  endfunction

  // front end
  ctl_t              f_ctl;
  logic [W-1:0]      f_rx, f_ry, f_rz, f_rs;
  logic [2*W-1:0]    f_sq;
  logic [3*W-1:0]    f_mags;
  logic [2:0]        f_sgns;

  // root chain links
  logic              rt_valid [W+1];
  logic              rt_ready [W+1];
  ctl_t              rt_ctl   [W+1];
  logic [2*W-1:0]    rt_d     [W+1];
  logic [W-1:0]      rt_r     [W+1];
  logic [RS_W-1:0]   rt_side  [W+1];

  // divide chain links
  logic                  dv_valid [QW+1];
  logic                  dv_ready [QW+1];
  ctl_t                  dv_ctl   [QW+1];
  logic [W-1:0]          dv_len   [QW+1];
  logic [2:0][LW-1:0]    dv_rem   [QW+1];
  logic [2:0][QW-1:0]    dv_q     [QW+1];
  logic [DS_W-1:0]       dv_side  [QW+1];

  // output stage
  ctl_t              e_ctl;
  logic [DS_W-1:0]   e_side;
  logic [W-1:0]      e_len;
  logic [2:0][QW-1:0] e_q;
  logic [W-1:0]      o_rv [3];
  logic [W-1:0]      o_rs;
  logic              o_ovf;
  logic              o_zl;
  logic signed [XW-1:0] qx [3];
  logic [W-1:0]      rx, ry, rz, rscalar;
  logic              zero_length, overflow;

  v3fx_front #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tuser),
    .ax        (s_tdata[0*W +: W]),
    .ay        (s_tdata[1*W +: W]),
    .az        (s_tdata[2*W +: W]),
    .bx        (s_tdata[3*W +: W]),
    .by        (s_tdata[4*W +: W]),
    .bz        (s_tdata[5*W +: W]),
    .scalar_t  (s_tdata[6*W +: W]),
    .out_valid (rt_valid[0]),
    .out_ready (rt_ready[0]),
    .out_ctl   (f_ctl),
    .res_x     (f_rx),
    .res_y     (f_ry),
    .res_z     (f_rz),
    .res_s     (f_rs),
    .sq        (f_sq),
    .mags      (f_mags),
    .sgns      (f_sgns)
  );

  assign rt_ctl[0]  = f_ctl;
  assign rt_d[0]    = f_sq;
  assign rt_r[0]    = '0;
  assign rt_side[0] = {f_sgns, f_mags, f_rs, f_rz, f_ry, f_rx};

  for (genvar k = 0; k < W; k++) begin : g_root
    v3fx_root_cell #(.DATA_WIDTH(W), .BIT(W-1-k), .SIDE_W(RS_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rt_valid[k]),
      .in_ready  (rt_ready[k]),
      .in_ctl    (rt_ctl[k]),
      .in_d      (rt_d[k]),
      .in_r      (rt_r[k]),
      .in_side   (rt_side[k]),
      .out_valid (rt_valid[k+1]),
      .out_ready (rt_ready[k+1]),
      .out_ctl   (rt_ctl[k+1]),
      .out_d     (rt_d[k+1]),
      .out_r     (rt_r[k+1]),
      .out_side  (rt_side[k+1])
    );
  end

  // numerator of each normalised component is |a| << FRAC_BITS
  assign dv_valid[0]    = rt_valid[W];
  assign rt_ready[W]    = dv_ready[0];
  assign dv_ctl[0]      = rt_ctl[W];
  assign dv_len[0]      = rt_r[W];
  assign dv_side[0]     = {rt_side[W][7*W +: 3], rt_side[W][4*W-1:0]};
  assign dv_q[0]        = '0;
  for (genvar k = 0; k < 3; k++) begin : g_num
    assign dv_rem[0][k] = LW'(rt_side[W][4*W + k*W +: W]) << FRAC_BITS;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    v3fx_div_cell #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .BIT(QW-1-k),
                    .SIDE_W(DS_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[k]),
      .in_ready  (dv_ready[k]),
      .in_ctl    (dv_ctl[k]),
      .in_len    (dv_len[k]),
      .in_rem    (dv_rem[k]),
      .in_q      (dv_q[k]),
      .in_side   (dv_side[k]),
      .out_valid (dv_valid[k+1]),
      .out_ready (dv_ready[k+1]),
      .out_ctl   (dv_ctl[k+1]),
      .out_len   (dv_len[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_q     (dv_q[k+1]),
      .out_side  (dv_side[k+1])
    );
  end

  assign e_ctl  = dv_ctl[QW];
  assign e_side = dv_side[QW];
  assign e_len  = dv_len[QW];
  assign e_q    = dv_q[QW];
  assign dv_ready[QW] = !m_tvalid || m_tready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_rv[i] = e_side[i*W +: W];
      qx[i]   = e_side[4*W + i] ? -XW'(e_q[i]) : XW'(e_q[i]);
    end
    o_rs  = e_side[3*W +: W];
    o_ovf = e_ctl.ovf;
    o_zl  = e_ctl.zl;
    case (e_ctl.func)
      FN_NORM: begin
        if (!e_ctl.zl) begin
          for (int i = 0; i < 3; i++) begin
            o_rv[i] = sat_x(qx[i]);
            o_ovf   = o_ovf | (qx[i] > MAXX) | (qx[i] < MINX);
          end
        end
      end
      FN_LEN: begin
        o_rs  = e_len[W-1] ? MAXX[W-1:0] : e_len;
        o_ovf = e_len[W-1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dv_ready[QW]) begin
      m_tvalid <= dv_valid[QW];
    end
    if (dv_ready[QW] && dv_valid[QW]) begin
      rx          <= o_rv[0];
      ry          <= o_rv[1];
      rz          <= o_rv[2];
      rscalar     <= o_rs;
      zero_length <= o_zl;
      overflow    <= o_ovf;
    end
  end

  assign m_tdata = OUT_TW'({rscalar, rz, ry, rx});
  assign m_tuser = {overflow, zero_length};

endmodule

[rtl/core/v3fx_front.sv]
// Front end: operand select, product stage and combine/saturate stage.
module v3fx_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [v3fx_pkg::FUNC_W-1:0]  func,
  input  logic signed [DATA_WIDTH-1:0] ax,
  input  logic signed [DATA_WIDTH-1:0] ay,
  input  logic signed [DATA_WIDTH-1:0] az,
  input  logic signed [DATA_WIDTH-1:0] bx,
  input  logic signed [DATA_WIDTH-1:0] by,
  input  logic signed [DATA_WIDTH-1:0] bz,
  input  logic signed [DATA_WIDTH-1:0] scalar_t,
  output logic                         out_valid,
  input  logic                         out_ready,
  output v3fx_pkg::ctl_t               out_ctl,
  output logic [DATA_WIDTH-1:0]        res_x,
  output logic [DATA_WIDTH-1:0]        res_y,
  output logic [DATA_WIDTH-1:0]        res_z,
  output logic [DATA_WIDTH-1:0]        res_s,
  output logic [2*DATA_WIDTH-1:0]      sq,
  output logic [3*DATA_WIDTH-1:0]      mags,
  output logic [2:0]                   sgns
);
  import v3fx_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int OW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 4;
  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  function automatic logic [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > MAXV) begin
      return MAXV[W-1:0];
    end else if (v < MINV) begin
      return MINV[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic logic ov_w(input logic signed [SW-1:0] v);
    return (v > MAXV) || (v < MINV);
  endfunction

  logic signed [OW-1:0] ae [3];
  logic signed [OW-1:0] be [3];
  logic signed [OW-1:0] te;
  logic signed [OW-1:0] opa [6];
  logic signed [OW-1:0] opb [6];

  // stage 1: operands
  logic                 v1;
  func_t                fn1;
  logic signed [W-1:0]  a1 [3];
  logic signed [OW-1:0] opa1 [6];
  logic signed [OW-1:0] opb1 [6];
  // stage 2: products
  logic                 v2;
  func_t                fn2;
  logic signed [W-1:0]  a2 [3];
  logic signed [PW-1:0] p2 [6];
  // stage 3 combine
  logic signed [SW-1:0] sum3;
  logic signed [SW-1:0] cr [3];
  logic signed [SW-1:0] term [3];
  logic [W-1:0]         rv [3];
  logic [W-1:0]         rsv;
  logic                 ovf_c;
  logic                 zl_c;
  logic                 rdy1, rdy2, rdy3;

  assign ae[0] = OW'(ax);
  assign ae[1] = OW'(ay);
  assign ae[2] = OW'(az);
  assign be[0] = OW'(bx);
  assign be[1] = OW'(by);
  assign be[2] = OW'(bz);
  assign te    = OW'(scalar_t);

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    case (func_t'(func))
      FN_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = ae[i];
          opb[i] = be[i];
        end
      end
      FN_CROSS: begin
        opa[0] = ae[1]; opb[0] = be[2];
        opa[1] = ae[2]; opb[1] = be[1];
        opa[2] = ae[2]; opb[2] = be[0];
        opa[3] = ae[0]; opb[3] = be[2];
        opa[4] = ae[0]; opb[4] = be[1];
        opa[5] = ae[1]; opb[5] = be[0];
      end
      FN_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = ae[i];
          opb[i] = te;
        end
      end
      FN_LERP: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = te;
          opb[i] = be[i] - ae[i];
        end
      end
      FN_NORM, FN_LEN, FN_LENSQ: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = ae[i];
          opb[i] = ae[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      fn1   <= func_t'(func);
      a1[0] <= ax;
      a1[1] <= ay;
      a1[2] <= az;
      opa1  <= opa;
      opb1  <= opb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      fn2 <= fn1;
      a2  <= a1;
      for (int i = 0; i < 6; i++) begin
        p2[i] <= opa1[i] * opb1[i];
      end
    end
  end

  always_comb begin
    sum3 = SW'(p2[0]) + SW'(p2[1]) + SW'(p2[2]);
    cr[0] = SW'(p2[0]) - SW'(p2[1]);
    cr[1] = SW'(p2[2]) - SW'(p2[3]);
    cr[2] = SW'(p2[4]) - SW'(p2[5]);
    for (int i = 0; i < 3; i++) begin
      term[i] = '0;
      rv[i]   = '0;
    end
    rsv   = '0;
    ovf_c = 1'b0;
    zl_c  = 1'b0;
    case (fn2)
      FN_DOT: begin
        rsv   = sat_w(sum3 >>> FRAC_BITS);
        ovf_c = ov_w(sum3 >>> FRAC_BITS);
      end
      FN_CROSS, FN_SCALE, FN_LERP: begin
        for (int i = 0; i < 3; i++) begin
          if (fn2 == FN_CROSS) begin
            term[i] = cr[i] >>> FRAC_BITS;
          end else if (fn2 == FN_SCALE) begin
            term[i] = SW'(p2[i]) >>> FRAC_BITS;
          end else begin
            term[i] = SW'(a2[i]) + (SW'(p2[i]) >>> FRAC_BITS);
          end
          rv[i] = sat_w(term[i]);
          ovf_c = ovf_c | ov_w(term[i]);
        end
      end
      FN_NORM: begin
        zl_c = (sum3 == '0);
      end
      FN_LENSQ: begin
        rsv   = sat_w(sum3 >>> FRAC_BITS);
        ovf_c = ov_w(sum3 >>> FRAC_BITS);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
    if (rdy3 && v2) begin
      out_ctl.func <= fn2;
      out_ctl.zl   <= zl_c;
      out_ctl.ovf  <= ovf_c;
      res_x <= rv[0];
      res_y <= rv[1];
      res_z <= rv[2];
      res_s <= rsv;
      sq    <= sum3[2*W-1:0];
      for (int i = 0; i < 3; i++) begin
        mags[i*W +: W] <= a2[i][W-1] ? W'(-a2[i]) : W'(a2[i]);
        sgns[i]        <= a2[i][W-1];
      end
    end
  end

endmodule

[rtl/core/v3fx_root_cell.sv]
// Square-root cell: settles one root bit per stage.
module v3fx_root_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int BIT        = 0,
  parameter int SIDE_W     = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  v3fx_pkg::ctl_t          in_ctl,
  input  logic [2*DATA_WIDTH-1:0] in_d,
  input  logic [DATA_WIDTH-1:0]   in_r,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  input  logic                    out_ready,
  output v3fx_pkg::ctl_t          out_ctl,
  output logic [2*DATA_WIDTH-1:0] out_d,
  output logic [DATA_WIDTH-1:0]   out_r,
  output logic [SIDE_W-1:0]       out_side
);
  import v3fx_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int DW = 2 * W + 1;
  localparam logic [DW-1:0] ONE = DW'(1);

  // d holds radicand minus root squared; trial adds 2^BIT to the root
  logic [DW-1:0] trial;
  logic [DW-1:0] diff;
  logic          ge;

  assign trial    = (DW'(in_r) << (BIT + 1)) + (ONE << (2 * BIT));
  assign ge       = DW'(in_d) >= trial;
  assign diff     = DW'(in_d) - trial;
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctl  <= in_ctl;
      out_side <= in_side;
      out_d    <= ge ? diff[2*W-1:0] : in_d;
      out_r    <= ge ? (in_r | (W'(1) << BIT)) : in_r;
    end
  end

endmodule

[rtl/core/v3fx_div_cell.sv]
// Divide cell: one quotient bit per stage for all three components.
module v3fx_div_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int BIT        = 0,
  parameter int SIDE_W     = 1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  v3fx_pkg::ctl_t                           in_ctl,
  input  logic [DATA_WIDTH-1:0]                    in_len,
  input  logic [2:0][DATA_WIDTH+FRAC_BITS+1:0]     in_rem,
  input  logic [2:0][FRAC_BITS+1:0]                in_q,
  input  logic [SIDE_W-1:0]                        in_side,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output v3fx_pkg::ctl_t                           out_ctl,
  output logic [DATA_WIDTH-1:0]                    out_len,
  output logic [2:0][DATA_WIDTH+FRAC_BITS+1:0]     out_rem,
  output logic [2:0][FRAC_BITS+1:0]                out_q,
  output logic [SIDE_W-1:0]                        out_side
);
  import v3fx_pkg::*;

  localparam int LW = DATA_WIDTH + FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 2;

  logic [LW-1:0] dsh;
  logic [2:0]    ge;

  assign dsh      = LW'(in_len) << BIT;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ge[k] = in_rem[k] >= dsh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctl  <= in_ctl;
      out_len  <= in_len;
      out_side <= in_side;
      for (int k = 0; k < 3; k++) begin
        out_rem[k] <= ge[k] ? (in_rem[k] - dsh) : in_rem[k];
        out_q[k]   <= ge[k] ? (in_q[k] | (QW'(1) << BIT)) : in_q[k];
      end
    end
  end

endmodule

[rtl/core/v3fx_checker.sv]
// Port-level checks for the vector unit, bound to the top level.
module v3fx_checker #(
  parameter int DATA_WIDTH = v3fx_pkg::DATA_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic [1:0]                        m_tuser
);
  import v3fx_pkg::*;

  localparam int W = DATA_WIDTH;

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn before transfer");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // zero normalise never saturates
  a_zl_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("zero length with overflow");

  a_zl_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[4*W-1:0] == '0)
    else $error("zero length with non-zero data");

endmodule

bind vector3_fixed_point_alu_top v3fx_checker #(.DATA_WIDTH(DATA_WIDTH)) u_v3fx_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[sim/vector3_fixed_point_alu_top_tb.sv]
// Testbench for the fixed-point 3D vector unit: directed and random operations checked in order.
module vector3_fixed_point_alu_top_tb;
  import v3fx_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [FUNC_W-1:0] FN_UNDEF = 3'd7;

  typedef struct packed {
    logic [DW-1:0] rx, ry, rz, rs;
    logic          zl, ovf;
  } vres_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7*DW-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [4*DW-1:0] m_tdata;
  logic [1:0] m_tuser;

  vres_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  vector3_fixed_point_alu_top i_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("vector3_fixed_point_alu_top_tb: FAIL");
      $finish;
    end
  end

  // clamp a wide value to DW bits
  function automatic logic [DW-1:0] clamp(input logic signed [127:0] v, inout logic ovf);
    logic signed [127:0] maxv, minv;
    maxv = (128'sd1 <<< (DW - 1)) - 1;
    minv = -maxv - 1;
    if (v > maxv) begin
      ovf = 1'b1;
      return maxv[DW-1:0];
    end
    if (v < minv) begin
      ovf = 1'b1;
      return minv[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] s);
    logic [63:0] r, c;
    r = '0;
    for (int i = 50; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic vres_t predict_vector_op(input logic [FUNC_W-1:0] fn,
                                              input logic [7*DW-1:0] d);
    logic signed [127:0] a[3], b[3], t, sq, v, num, l;
    logic [DW-1:0] r[3];
    logic [DW-1:0] rs;
    logic zl, ovf;
    logic [63:0] q, c, len;
    vres_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(d[i*DW +: DW]);
      b[i] = $signed(d[(i+3)*DW +: DW]);
      r[i] = '0;
    end
    t = $signed(d[6*DW +: DW]);
    rs = '0;
    zl = 1'b0;
    ovf = 1'b0;
    sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    case (fn)
      FN_DOT: rs = clamp((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FB, ovf);
      FN_CROSS: begin
        r[0] = clamp((a[1]*b[2] - a[2]*b[1]) >>> FB, ovf);
        r[1] = clamp((a[2]*b[0] - a[0]*b[2]) >>> FB, ovf);
        r[2] = clamp((a[0]*b[1] - a[1]*b[0]) >>> FB, ovf);
      end
      FN_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp((a[i]*t) >>> FB, ovf);
      FN_LERP: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + ((t*(b[i]-a[i])) >>> FB), ovf);
      FN_NORM: begin
        if (sq == 0) begin
          zl = 1'b1;
        end else begin
          len = int_sqrt(sq);
          l = $signed({64'd0, len});
          for (int i = 0; i < 3; i++) begin
            num = (a[i] < 0 ? -a[i] : a[i]) <<< FB;
            q = '0;
            for (int k = FB + 1; k >= 0; k--) begin
              c = q | (64'd1 << k);
              if ($signed({64'd0, c}) * l <= num) q = c;
            end
            v = $signed({64'd0, q});
            r[i] = clamp(a[i] < 0 ? -v : v, ovf);
          end
        end
      end
      FN_LEN: rs = clamp($signed({64'd0, int_sqrt(sq)}), ovf);
      FN_LENSQ: rs = clamp(sq >>> FB, ovf);
      default: ;
    endcase
    res.rx = r[0];
    res.ry = r[1];
    res.rz = r[2];
    res.rs = rs;
    res.zl = zl;
    res.ovf = ovf;
    return res;
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [7*DW-1:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= fn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_vector_op(fn, d));
    @(negedge clk);
  endtask

  task automatic go_quiet();
    s_tvalid <= 1'b0;
    while (expected_results.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    vres_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[0 +: DW], m_tdata[DW +: DW], m_tdata[2*DW +: DW],
             m_tdata[3*DW +: DW], m_tuser[0], m_tuser[1]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected rx=%h ry=%h rz=%h rs=%h zl=%b ovf=%b", $time,
                   exp_r.rx, exp_r.ry, exp_r.rz, exp_r.rs, exp_r.zl, exp_r.ovf);
          $display("%0t:          actual   rx=%h ry=%h rz=%h rs=%h zl=%b ovf=%b", $time,
                   got.rx, got.ry, got.rz, got.rs, got.zl, got.ovf);
          errors++;
        end
      end
    end
  end

  function automatic logic [DW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(1) ? 32'h00010000 : 32'hffff0000;
      2: return $urandom_range(1) ? 32'd0 : 32'd1;
      3: return 32'($signed(17'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7*DW-1:0] rand_vectors();
    logic [7*DW-1:0] d;
    for (int i = 0; i < 7; i++) d[i*DW +: DW] = rand_comp();
    return d;
  endfunction

  task automatic test_directed();
    logic [7*DW-1:0] d;
    for (int f = 0; f < 8; f++) begin
      send_op(f[FUNC_W-1:0], '0);
      send_op(f[FUNC_W-1:0], {7{32'h7fffffff}});
      send_op(f[FUNC_W-1:0], {7{32'h80000000}});
    end
    d = {32'h00008000, 32'h00030000, 32'hfffe0000, 32'h00010000,
         32'h00000000, 32'h00040000, 32'h00030000};
    send_op(FN_NORM, d);
    send_op(FN_LERP, d);
    go_quiet();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    logic [FUNC_W-1:0] fn;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(49) == 0) ? FN_UNDEF : FUNC_W'($urandom_range(6));
      send_op(fn, rand_vectors());
    end
    go_quiet();
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 300;
    for (int i = 0; i < 150; i++) send_op(FUNC_W'($urandom_range(6)), rand_vectors());
    go_quiet();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300, 0, 0);
    test_random(250, 49, 0);
    test_random(250, 0, 49);
    test_random(250, 26, 26);
    test_back_pressure();
    if (errors == 0) begin
      $display("vector3_fixed_point_alu_top_tb: PASS");
    end else begin
      $display("vector3_fixed_point_alu_top_tb: FAIL");
    end
    $finish;
  end

endmodule
